[hw/rtl/gle_pkg.sv]
// Shared constants and types for the GIF LZW encoder.
`default_nettype none
package gle_pkg;
  localparam int HASH_ENTRIES = 5003;
  localparam int MAX_CODE_BITS = 12;
  localparam int ADDR_W = $clog2(HASH_ENTRIES);
  localparam int ACC_W = 20;

  typedef struct packed {
    logic [MAX_CODE_BITS-1:0] code;
    logic [MAX_CODE_BITS-1:0] prefix;
    logic [7:0]               suffix;
  } entry_t;

  typedef struct packed {
    logic       push;
    logic       fin;
    logic [7:0] data;
    logic       eos;
  } bo_cmd_t;

  typedef struct packed {
    logic can;
    logic held;
  } bo_stat_t;
endpackage
`default_nettype wire

[hw/rtl/gle_if.sv]
// Channel interfaces for pixel input and code byte output.
`default_nettype none
interface gle_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_index;
  logic       last_pixel;
  modport source (output valid, pixel_index, last_pixel, input ready);
  modport sink (input valid, pixel_index, last_pixel, output ready);
endinterface

interface gle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_of_run;
  logic       end_of_stream;
  modport source (output valid, code_byte, last_of_run, end_of_stream, input ready);
  modport sink (input valid, code_byte, last_of_run, end_of_stream, output ready);
endinterface
`default_nettype wire

[hw/rtl/gle_byte_out.sv]
// Byte hold stage and output register that marks the final byte of a run.
`default_nettype none
module gle_byte_out (
  input  wire               clk,
  input  wire               rst,
  input  wire gle_pkg::bo_cmd_t cmd,
  output gle_pkg::bo_stat_t stat,
  gle_byte_if.source        codes
);
  logic       held_v;
  logic [7:0] held;
  logic       can;
  logic       load;

  assign can = !codes.valid || codes.ready;
  assign load = can && held_v && (cmd.push || cmd.fin);
  assign stat.can = can;
  assign stat.held = held_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_v <= 1'b0;
      codes.valid <= 1'b0;
    end else begin
      if (load) begin
        codes.valid <= 1'b1;
        codes.code_byte <= held;
        codes.last_of_run <= !cmd.push;
        codes.end_of_stream <= !cmd.push && cmd.eos;
      end else if (codes.ready) begin
        codes.valid <= 1'b0;
      end
      if (can && cmd.push) begin
        held <= cmd.data;
        held_v <= 1'b1;
      end else if (can && cmd.fin) begin
        held_v <= 1'b0;
      end
    end
  end

  a_fin_empties: assert property (@(posedge clk) disable iff (rst)
    (can && cmd.fin && !cmd.push) |=> !held_v) else $error("hold not drained on finish");
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (can && cmd.push) |=> held_v) else $error("hold empty after push");
  a_run_end: assert property (@(posedge clk) disable iff (rst)
    (codes.valid && codes.end_of_stream) |-> codes.last_of_run)
    else $error("end of stream without end of run");
endmodule
`default_nettype wire

[hw/rtl/gif_lzw_encoder.sv]
// Top level of the GIF LZW encoder: hash dictionary, sequencer and bit packer.
//  channel  | dir | payload                                  | handshake
//  pixels   | in  | pixel_index[7:0], last_pixel             | valid/ready
//  codes    | out | code_byte[7:0], last_of_run, end_of_stream | valid/ready
//  cfg      | in  | cfg_data[3:0] (min_code_size)            | cfg_we
// A dictionary hit steps through accept, read, compare, last check and finish; each
// extra probe adds a read and a compare. Each emitted code adds an emit step and a drain
// step per byte, and a miss adds an insert step.
// A stream start and a full table run a clear sweep over all 5003 table entries.
// rst is synchronous; the table is swept at the first pixel, not at reset.
// A stalled output holds the sequencer in place; pixels is ready only between items.
`default_nettype none
module gif_lzw_encoder (
  input  wire        clk,
  input  wire        rst,
  input  wire        cfg_we,
  input  wire  [3:0] cfg_data,
  gle_pix_if.sink    pixels,
  gle_byte_if.source codes
);
  localparam int AW = gle_pkg::ADDR_W;
  localparam int CW = gle_pkg::MAX_CODE_BITS;
  localparam logic [AW:0] HASH = (AW+1)'(gle_pkg::HASH_ENTRIES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(gle_pkg::HASH_ENTRIES - 1);
  localparam logic [CW:0] CODE_SPACE = (CW+1)'(1) << CW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR = 4'd1;
  localparam logic [3:0] S_RD = 4'd2;
  localparam logic [3:0] S_CMP = 4'd3;
  localparam logic [3:0] S_EMIT = 4'd4;
  localparam logic [3:0] S_DRAIN = 4'd5;
  localparam logic [3:0] S_SEED = 4'd6;
  localparam logic [3:0] S_MISS = 4'd7;
  localparam logic [3:0] S_FULL = 4'd8;
  localparam logic [3:0] S_LASTCHK = 4'd9;
  localparam logic [3:0] S_ENDC = 4'd10;
  localparam logic [3:0] S_PART = 4'd11;
  localparam logic [3:0] S_FIN = 4'd12;

  gle_pkg::entry_t mem [gle_pkg::HASH_ENTRIES];
  gle_pkg::entry_t rd_data;
  gle_pkg::entry_t wr_data;
  logic            mem_we;
  logic [AW-1:0]   wr_addr;

  logic [3:0]    state;
  logic [3:0]    cont;
  logic [3:0]    min_size;
  logic [3:0]    act_size;
  logic [7:0]    pix;
  logic          last_item;
  logic [CW-1:0] pending;
  logic [CW:0]   next_free;
  logic [3:0]    width;
  logic [CW:0]   limit;
  logic [gle_pkg::ACC_W-1:0] acc;
  logic [4:0]    acc_bits;
  logic          started;
  logic [AW-1:0] k;
  logic [AW-1:0] disp;
  logic [AW:0]   probes;
  logic          slot;
  logic [AW-1:0] clr_cnt;
  logic [CW-1:0] code;

  gle_pkg::bo_cmd_t  bo_cmd;
  gle_pkg::bo_stat_t bo_stat;

  logic [3:0]    new_size;
  logic [3:0]    use_size;
  logic [8:0]    clear_val;
  logic [8:0]    use_clear;
  logic [7:0]    pix_m;
  logic [AW:0]   ksum;
  logic [AW-1:0] khash;
  logic [AW-1:0] step;
  logic [CW-1:0] wmask;
  logic [3:0]    width_up;
  logic          match;

  always_comb begin
    if (min_size < 4'd2) begin
      new_size = 4'd2;
    end else if (min_size > 4'd8) begin
      new_size = 4'd8;
    end else begin
      new_size = min_size;
    end
    use_size = started ? act_size : new_size;
    clear_val = 9'(1) << act_size;
    use_clear = 9'(1) << use_size;
    pix_m = pixels.pixel_index & 8'(use_clear - 9'd1);
    ksum = (AW+1)'({pix_m, 4'b0000}) + (AW+1)'(pending);
    khash = (ksum >= HASH) ? AW'(ksum - HASH) : AW'(ksum);
    if (probes == '0) begin
      step = (k != '0) ? AW'(HASH - (AW+1)'(k)) : AW'(1);
    end else begin
      step = disp;
    end
    wmask = {CW{1'b1}} >> (4'(CW) - width);
    width_up = width + 4'd1;
    match = (rd_data.prefix == pending) && (rd_data.suffix == pix);
  end

  always_comb begin
    mem_we = 1'b0;
    wr_addr = clr_cnt;
    wr_data = '0;
    if (state == S_CLR) begin
      mem_we = 1'b1;
    end else if (state == S_MISS && next_free < CODE_SPACE && slot) begin
      mem_we = 1'b1;
      wr_addr = k;
      wr_data.code = CW'(next_free);
      wr_data.prefix = pending;
      wr_data.suffix = pix;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[k];
  end

  always_comb begin
    bo_cmd.push = bo_stat.can && ((state == S_DRAIN && acc_bits >= 5'd8) ||
                                  (state == S_PART && acc_bits != '0));
    bo_cmd.fin = bo_stat.can && state == S_FIN;
    bo_cmd.data = acc[7:0];
    bo_cmd.eos = last_item;
  end

  assign pixels.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      min_size <= 4'd8;
      act_size <= 4'd8;
      pending <= '0;
      next_free <= (CW+1)'(258);
      width <= 4'd9;
      limit <= (CW+1)'(511);
      acc <= '0;
      acc_bits <= '0;
      started <= 1'b0;
    end else begin
      if (cfg_we) begin
        min_size <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (pixels.valid) begin
            pix <= pix_m;
            last_item <= pixels.last_pixel;
            k <= khash;
            probes <= '0;
            slot <= 1'b1;
            if (!started) begin
              act_size <= new_size;
              next_free <= (CW+1)'(use_clear) + (CW+1)'(2);
              width <= new_size + 4'd1;
              limit <= ((CW+1)'(1) << (new_size + 4'd1)) - (CW+1)'(1);
              acc <= '0;
              acc_bits <= '0;
              clr_cnt <= '0;
              state <= S_CLR;
            end else begin
              state <= S_RD;
            end
          end
        end
        S_CLR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == LAST_ADDR) begin
            code <= CW'(clear_val);
            if (!started) begin
              cont <= S_SEED;
            end else begin
              next_free <= (CW+1)'(clear_val) + (CW+1)'(2);
              cont <= S_FULL;
            end
            state <= S_EMIT;
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (rd_data.code == '0) begin
            code <= pending;
            cont <= S_MISS;
            state <= S_EMIT;
          end else if (match) begin
            pending <= rd_data.code;
            state <= S_LASTCHK;
          end else if (probes >= HASH) begin
            slot <= 1'b0;
            code <= pending;
            cont <= S_MISS;
            state <= S_EMIT;
          end else begin
            disp <= step;
            k <= (k >= step) ? k - step : AW'((AW+1)'(k) + HASH - (AW+1)'(step));
            probes <= probes + (AW+1)'(1);
            state <= S_RD;
          end
        end
        S_EMIT: begin
          acc <= acc | (gle_pkg::ACC_W'(code & wmask) << acc_bits);
          acc_bits <= acc_bits + 5'(width);
          if (next_free > limit && width < 4'(CW)) begin
            width <= width_up;
            limit <= (width_up == 4'(CW)) ? CODE_SPACE :
                     ((CW+1)'(1) << width_up) - (CW+1)'(1);
          end
          state <= S_DRAIN;
        end
        S_DRAIN: begin
          if (acc_bits >= 5'd8) begin
            if (bo_stat.can) begin
              acc <= acc >> 8;
              acc_bits <= acc_bits - 5'd8;
            end
          end else begin
            state <= cont;
          end
        end
        S_SEED: begin
          pending <= CW'(pix);
          started <= 1'b1;
          state <= S_LASTCHK;
        end
        S_MISS: begin
          if (next_free < CODE_SPACE) begin
            if (slot) begin
              next_free <= next_free + (CW+1)'(1);
            end
            pending <= CW'(pix);
            state <= S_LASTCHK;
          end else begin
            clr_cnt <= '0;
            state <= S_CLR;
          end
        end
        S_FULL: begin
          width <= act_size + 4'd1;
          limit <= ((CW+1)'(1) << (act_size + 4'd1)) - (CW+1)'(1);
          pending <= CW'(pix);
          state <= S_LASTCHK;
        end
        S_LASTCHK: begin
          if (last_item) begin
            code <= pending;
            cont <= S_ENDC;
            state <= S_EMIT;
          end else begin
            state <= S_FIN;
          end
        end
        S_ENDC: begin
          code <= CW'(clear_val) + CW'(1);
          cont <= S_PART;
          state <= S_EMIT;
        end
        S_PART: begin
          if (acc_bits == '0 || bo_stat.can) begin
            acc <= '0;
            acc_bits <= '0;
            started <= 1'b0;
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (bo_stat.can) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  gle_byte_out u_byte_out (
    .clk   (clk),
    .rst   (rst),
    .cmd   (bo_cmd),
    .stat  (bo_stat),
    .codes (codes)
  );

  a_idle_acc: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> (acc_bits < 5'd8)) else $error("bits left over between items");
  a_width: assert property (@(posedge clk) disable iff (rst)
    (width >= 4'd3) && (width <= 4'(CW))) else $error("code width out of range");
  a_free: assert property (@(posedge clk) disable iff (rst)
    next_free <= CODE_SPACE) else $error("next free code past code space");
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !bo_stat.held) else $error("byte held between items");
endmodule
`default_nettype wire
